[design/assert_macros.svh]
// Assertion macros shared by the control chart rule checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CCRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Clocked property with a caller-supplied message.
`define CCRC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[design/ccrc_pkg.sv]
// Package for the control chart rule checker: widths, codes, run limits, types.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package ccrc_pkg;

    // Default widths and fixed field widths
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int MEAN_WIDTH         = 16;
    localparam int SIGMA_WIDTH        = 15;
    localparam int CFG_DATA_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH    = 1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MEAN_LEVEL = 1'b0,
        CFG_SIGMA      = 1'b1
    } cfg_index_e;

    // Position of a sample relative to one band
    typedef enum logic [1:0] {
        BAND_IN    = 2'd0,
        BAND_ABOVE = 2'd1,
        BAND_BELOW = 2'd2
    } band_e;

    typedef struct packed {
        band_e band3;
        band_e band2;
        band_e band1;
        logic  within_one;
        logic  above_mean;
        logic  below_mean;
    } band_info_t;

    typedef struct packed {
        logic beyond_three_sigma;
        logic nine_same_side;
        logic six_trend;
        logic fourteen_alternating;
        logic two_of_three_beyond_two;
        logic four_of_five_beyond_one;
        logic fifteen_within_one;
        logic eight_outside_both_sides;
    } rule_flags_t;

    // Run limits and majority count; every run saturates at its limit
    localparam logic signed [4:0] SIDE_RUN_MAX    = 5'sd9;
    localparam logic signed [3:0] TREND_RUN_MAX   = 4'sd6;
    localparam logic [3:0]        ALT_RUN_MAX     = 4'd14;
    localparam logic [3:0]        WITHIN_RUN_MAX  = 4'd15;
    localparam logic [3:0]        OUTSIDE_RUN_MAX = 4'd8;
    localparam logic [2:0]        MAJORITY_COUNT  = 3'd4;

endpackage

[design/ccrc_ifs.sv]
// Handshake interfaces of the control chart rule checker: samples, results, config.
// Depends on ccrc_pkg for default widths and config field widths.
`timescale 1ns / 1ps

interface ccrc_sample_if #(
    parameter int SAMPLE_WIDTH = ccrc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_series;

    modport source (output valid, sample, start_series, input ready);
    modport sink   (input valid, sample, start_series, output ready);
endinterface

interface ccrc_result_if #(
    parameter int POSITION_WIDTH = ccrc_pkg::POSITION_WIDTH_DEF
);
    logic                      valid;
    logic                      ready;
    logic [POSITION_WIDTH-1:0] position;
    logic                      beyond_three_sigma;
    logic                      nine_same_side;
    logic                      six_trend;
    logic                      fourteen_alternating;
    logic                      two_of_three_beyond_two;
    logic                      four_of_five_beyond_one;
    logic                      fifteen_within_one;
    logic                      eight_outside_both_sides;

    modport source (output valid, position, beyond_three_sigma, nine_same_side, six_trend,
                    fourteen_alternating, two_of_three_beyond_two,
                    four_of_five_beyond_one, fifteen_within_one,
                    eight_outside_both_sides, input ready);
    modport sink   (input valid, position, beyond_three_sigma, nine_same_side, six_trend,
                    fourteen_alternating, two_of_three_beyond_two,
                    four_of_five_beyond_one, fifteen_within_one,
                    eight_outside_both_sides, output ready);
endinterface

interface ccrc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ccrc_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [ccrc_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/ccrc_cfg_regs.sv]
// Configuration registers: centre line and sigma, written over the config channel.
// Depends on ccrc_pkg and ccrc_ifs.
`timescale 1ns / 1ps

module ccrc_cfg_regs (
    input  logic                                    clk,
    input  logic                                    rst_n,
    ccrc_cfg_if.sink                                cfg,
    output logic signed [ccrc_pkg::MEAN_WIDTH-1:0]  mean_level,
    output logic [ccrc_pkg::SIGMA_WIDTH-1:0]        sigma
);

    logic signed [ccrc_pkg::MEAN_WIDTH-1:0] mean_reg, mean_next;
    logic [ccrc_pkg::SIGMA_WIDTH-1:0]       sigma_reg, sigma_next;

    // Writes are always accepted: ready is held high
    assign cfg.ready = 1'b1;

    // Register write decode
    always_comb
    begin
        mean_next  = mean_reg;
        sigma_next = sigma_reg;
        if (cfg.valid)
        begin
            case (ccrc_pkg::cfg_index_e'(cfg.index))
                ccrc_pkg::CFG_MEAN_LEVEL: mean_next  = cfg.data[ccrc_pkg::MEAN_WIDTH-1:0];
                ccrc_pkg::CFG_SIGMA:      sigma_next = cfg.data[ccrc_pkg::SIGMA_WIDTH-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            sigma_reg <= '0;
        end
        else
        begin
            mean_reg  <= mean_next;
            sigma_reg <= sigma_next;
        end
    end

    assign mean_level = mean_reg;
    assign sigma      = sigma_reg;

endmodule

[design/ccrc_band_class.sv]
// Band classifier: places a sample against the mean and the 1, 2, 3 sigma bands.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps

module ccrc_band_class #(
    parameter int SAMPLE_WIDTH = ccrc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0]          sample,
    input  logic signed [ccrc_pkg::MEAN_WIDTH-1:0]  mean_level,
    input  logic [ccrc_pkg::SIGMA_WIDTH-1:0]        sigma,
    output ccrc_pkg::band_info_t                    info
);

    // Wide enough for the sample and for mean +/- 3 sigma without wrapping
    localparam int CMP_W = ((SAMPLE_WIDTH > 19) ? SAMPLE_WIDTH : 19) + 1;

    logic signed [CMP_W-1:0] s_ext, m_ext;
    logic signed [CMP_W-1:0] sig1, sig2, sig3;
    logic signed [CMP_W-1:0] hi1, hi2, hi3, lo1, lo2, lo3;

    assign s_ext = {{(CMP_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
    assign m_ext = {{(CMP_W-ccrc_pkg::MEAN_WIDTH){mean_level[ccrc_pkg::MEAN_WIDTH-1]}},
                    mean_level};
    assign sig1  = {{(CMP_W-ccrc_pkg::SIGMA_WIDTH){1'b0}}, sigma};
    assign sig2  = sig1 <<< 1;
    assign sig3  = sig1 + sig2;

    // Band edges
    assign hi1 = m_ext + sig1;
    assign hi2 = m_ext + sig2;
    assign hi3 = m_ext + sig3;
    assign lo1 = m_ext - sig1;
    assign lo2 = m_ext - sig2;
    assign lo3 = m_ext - sig3;

    // Strict compares: a sample on an edge counts as inside its band, but not as within one sigma
    always_comb
    begin
        info.band1 = (s_ext > hi1) ? ccrc_pkg::BAND_ABOVE :
                     (s_ext < lo1) ? ccrc_pkg::BAND_BELOW : ccrc_pkg::BAND_IN;
        info.band2 = (s_ext > hi2) ? ccrc_pkg::BAND_ABOVE :
                     (s_ext < lo2) ? ccrc_pkg::BAND_BELOW : ccrc_pkg::BAND_IN;
        info.band3 = (s_ext > hi3) ? ccrc_pkg::BAND_ABOVE :
                     (s_ext < lo3) ? ccrc_pkg::BAND_BELOW : ccrc_pkg::BAND_IN;
        info.within_one = (s_ext < hi1) && (s_ext > lo1);
        info.above_mean = (s_ext > m_ext);
        info.below_mean = (s_ext < m_ext);
    end

endmodule

[design/ccrc_rule_core.sv]
// Rule core: run counters and band history, rule flags and series position.
// Depends on ccrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccrc_rule_core #(
    parameter int SAMPLE_WIDTH   = ccrc_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = ccrc_pkg::POSITION_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           start_series,
    input  ccrc_pkg::band_info_t           info,
    output ccrc_pkg::rule_flags_t          flags,
    output logic [POSITION_WIDTH-1:0]      position
);

    // History state
    logic signed [SAMPLE_WIDTH-1:0] prev_sample_reg, prev_sample_next;
    logic                           prev_valid_reg, prev_valid_next;
    logic signed [4:0]              side_run_reg, side_run_next;
    logic signed [3:0]              trend_run_reg, trend_run_next;
    logic [3:0]                     alt_run_reg, alt_run_next;
    logic                           last_up_reg, last_up_next;
    ccrc_pkg::band_e                two_hist_reg [2];
    ccrc_pkg::band_e                one_hist_reg [4];
    logic [3:0]                     within_run_reg, within_run_next;
    logic [3:0]                     outside_run_reg, outside_run_next;
    logic                           seen_above_reg, seen_above_next;
    logic                           seen_below_reg, seen_below_next;
    logic [POSITION_WIDTH-1:0]      count_reg, count_next;

    // History as seen by this sample (cleared on series start)
    logic signed [SAMPLE_WIDTH-1:0] eff_prev;
    logic                           eff_prev_valid;
    logic signed [4:0]              eff_side;
    logic signed [3:0]              eff_trend;
    logic [3:0]                     eff_alt;
    logic                           eff_last_up;
    ccrc_pkg::band_e                eff_two [2];
    ccrc_pkg::band_e                eff_one [4];
    logic [3:0]                     eff_within;
    logic [3:0]                     eff_outside;
    logic                           eff_seen_above;
    logic                           eff_seen_below;
    logic [POSITION_WIDTH-1:0]      eff_count;

    logic       move_up;
    logic [2:0] cnt_above, cnt_below;

    always_comb
    begin
        eff_prev       = start_series ? '0 : prev_sample_reg;
        eff_prev_valid = start_series ? 1'b0 : prev_valid_reg;
        eff_side       = start_series ? '0 : side_run_reg;
        eff_trend      = start_series ? '0 : trend_run_reg;
        eff_alt        = start_series ? '0 : alt_run_reg;
        eff_last_up    = start_series ? 1'b0 : last_up_reg;
        eff_within     = start_series ? '0 : within_run_reg;
        eff_outside    = start_series ? '0 : outside_run_reg;
        eff_seen_above = start_series ? 1'b0 : seen_above_reg;
        eff_seen_below = start_series ? 1'b0 : seen_below_reg;
        eff_count      = start_series ? '0 : count_reg;
        for (int i = 0; i < 2; i++)
            eff_two[i] = start_series ? ccrc_pkg::BAND_IN : two_hist_reg[i];
        for (int i = 0; i < 4; i++)
            eff_one[i] = start_series ? ccrc_pkg::BAND_IN : one_hist_reg[i];
    end

    // Same-side run, signed: positive above the mean
    always_comb
    begin
        if (info.above_mean)
            side_run_next = (eff_side > 5'sd0) ?
                ((eff_side >= ccrc_pkg::SIDE_RUN_MAX) ? ccrc_pkg::SIDE_RUN_MAX
                                                      : eff_side + 5'sd1) : 5'sd1;
        else if (info.below_mean)
            side_run_next = (eff_side < 5'sd0) ?
                ((eff_side <= -ccrc_pkg::SIDE_RUN_MAX) ? -ccrc_pkg::SIDE_RUN_MAX
                                                       : eff_side - 5'sd1) : -5'sd1;
        else
            side_run_next = 5'sd0;
    end

    // Trend and alternation runs from the move against the previous sample
    assign move_up = (sample > eff_prev);

    always_comb
    begin
        trend_run_next = 4'sd0;
        alt_run_next   = 4'd1;
        last_up_next   = eff_last_up;
        if (eff_prev_valid && (sample != eff_prev))
        begin
            if (move_up)
                trend_run_next = (eff_trend > 4'sd0) ?
                    ((eff_trend >= ccrc_pkg::TREND_RUN_MAX) ? ccrc_pkg::TREND_RUN_MAX
                                                            : eff_trend + 4'sd1) : 4'sd1;
            else
                trend_run_next = (eff_trend < 4'sd0) ?
                    ((eff_trend <= -ccrc_pkg::TREND_RUN_MAX) ? -ccrc_pkg::TREND_RUN_MAX
                                                             : eff_trend - 4'sd1) : -4'sd1;

            if (eff_alt < 4'd2)
                alt_run_next = 4'd2;
            else if (move_up != eff_last_up)
                alt_run_next = (eff_alt >= ccrc_pkg::ALT_RUN_MAX) ? ccrc_pkg::ALT_RUN_MAX
                                                                 : eff_alt + 4'd1;
            else
                alt_run_next = 4'd2;
            last_up_next = move_up;
        end
    end

    // Four of five beyond one sigma: count each side over the window
    always_comb
    begin
        cnt_above = (info.band1 == ccrc_pkg::BAND_ABOVE) ? 3'd1 : 3'd0;
        cnt_below = (info.band1 == ccrc_pkg::BAND_BELOW) ? 3'd1 : 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            cnt_above = cnt_above + ((eff_one[i] == ccrc_pkg::BAND_ABOVE) ? 3'd1 : 3'd0);
            cnt_below = cnt_below + ((eff_one[i] == ccrc_pkg::BAND_BELOW) ? 3'd1 : 3'd0);
        end
    end

    // Within and outside one sigma runs
    always_comb
    begin
        within_run_next = info.within_one ?
            ((eff_within >= ccrc_pkg::WITHIN_RUN_MAX) ? ccrc_pkg::WITHIN_RUN_MAX
                                                      : eff_within + 4'd1) : 4'd0;
        if (info.band1 == ccrc_pkg::BAND_IN)
        begin
            outside_run_next = 4'd0;
            seen_above_next  = 1'b0;
            seen_below_next  = 1'b0;
        end
        else
        begin
            outside_run_next = (eff_outside >= ccrc_pkg::OUTSIDE_RUN_MAX) ?
                               ccrc_pkg::OUTSIDE_RUN_MAX : eff_outside + 4'd1;
            seen_above_next  = eff_seen_above || (info.band1 == ccrc_pkg::BAND_ABOVE);
            seen_below_next  = eff_seen_below || (info.band1 == ccrc_pkg::BAND_BELOW);
        end
    end

    // Position counter, saturating
    assign count_next       = (eff_count != '1) ? eff_count + 1'b1 : eff_count;
    assign prev_sample_next = sample;
    assign prev_valid_next  = 1'b1;

    // Rule flags
    always_comb
    begin
        flags.beyond_three_sigma       = (info.band3 != ccrc_pkg::BAND_IN);
        flags.nine_same_side           = (side_run_next == ccrc_pkg::SIDE_RUN_MAX) ||
                                         (side_run_next == -ccrc_pkg::SIDE_RUN_MAX);
        flags.six_trend                = (trend_run_next == ccrc_pkg::TREND_RUN_MAX) ||
                                         (trend_run_next == -ccrc_pkg::TREND_RUN_MAX);
        flags.fourteen_alternating     = (alt_run_next >= ccrc_pkg::ALT_RUN_MAX);
        flags.two_of_three_beyond_two  = (info.band2 != ccrc_pkg::BAND_IN) &&
                                         ((eff_two[0] == info.band2) ||
                                          (eff_two[1] == info.band2));
        flags.four_of_five_beyond_one  = (cnt_above >= ccrc_pkg::MAJORITY_COUNT) ||
                                         (cnt_below >= ccrc_pkg::MAJORITY_COUNT);
        flags.fifteen_within_one       = (within_run_next >= ccrc_pkg::WITHIN_RUN_MAX);
        flags.eight_outside_both_sides = (outside_run_next >= ccrc_pkg::OUTSIDE_RUN_MAX) &&
                                         seen_above_next && seen_below_next;
    end

    assign position = eff_count;

    // State update, one sample per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_valid_reg  <= 1'b0;
            side_run_reg    <= '0;
            trend_run_reg   <= '0;
            alt_run_reg     <= '0;
            last_up_reg     <= 1'b0;
            two_hist_reg[0] <= ccrc_pkg::BAND_IN;
            two_hist_reg[1] <= ccrc_pkg::BAND_IN;
            for (int i = 0; i < 4; i++)
                one_hist_reg[i] <= ccrc_pkg::BAND_IN;
            within_run_reg  <= '0;
            outside_run_reg <= '0;
            seen_above_reg  <= 1'b0;
            seen_below_reg  <= 1'b0;
            count_reg       <= '0;
        end
        else if (step)
        begin
            prev_sample_reg <= prev_sample_next;
            prev_valid_reg  <= prev_valid_next;
            side_run_reg    <= side_run_next;
            trend_run_reg   <= trend_run_next;
            alt_run_reg     <= alt_run_next;
            last_up_reg     <= last_up_next;
            two_hist_reg[1] <= eff_two[0];
            two_hist_reg[0] <= info.band2;
            for (int i = 1; i < 4; i++)
                one_hist_reg[i] <= eff_one[i-1];
            one_hist_reg[0] <= info.band1;
            within_run_reg  <= within_run_next;
            outside_run_reg <= outside_run_next;
            seen_above_reg  <= seen_above_next;
            seen_below_reg  <= seen_below_next;
            count_reg       <= count_next;
        end
    end

    // An alternating run leaves every trend run at one move
    `CCRC_ASSERT(a_alt_excludes_trend, clk, rst_n,
        step && flags.fourteen_alternating |-> !flags.six_trend)
    // Strictly within one sigma can never also be beyond three sigma
    `CCRC_ASSERT(a_within_excludes_beyond, clk, rst_n,
        step && flags.fifteen_within_one |-> !flags.beyond_three_sigma)
    // Eight outside and fifteen within cannot both complete on one sample
    `CCRC_ASSERT_MSG(a_outside_excludes_within, clk, rst_n,
        step && flags.eight_outside_both_sides |-> !flags.fifteen_within_one,
        "rule core: outside and within runs both complete")
    // A series start always reports position zero
    `CCRC_ASSERT(a_start_position_zero, clk, rst_n,
        step && start_series |-> (position == '0))

endmodule

[design/control_chart_rule_checker_unit.sv]
// Accepted words go to the input stage register, results to the output stage register.
// Throughput: one word per cycle unless results stall; the core updates all run state.
// The output register lets a new word enter while a finished result waits downstream.
// Reset (rst_n low, asynchronous) clears the config registers to zero, all run history,
// the position counter and both pipeline valid flags.
// Depends on ccrc_pkg, ccrc_ifs, ccrc_cfg_regs, ccrc_band_class, ccrc_rule_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module control_chart_rule_checker_unit #(
    parameter int SAMPLE_WIDTH   = ccrc_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = ccrc_pkg::POSITION_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ccrc_sample_if.sink   samples,
    ccrc_result_if.source results,
    ccrc_cfg_if.sink      cfg
);

    // Input stage
    logic                           in_valid_reg, in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                           in_start_reg;

    // Output stage
    logic                           out_valid_reg, out_valid_next;
    logic [POSITION_WIDTH-1:0]      out_position_reg;
    ccrc_pkg::rule_flags_t          out_flags_reg;

    logic                                   accept, advance, out_free;
    logic signed [ccrc_pkg::MEAN_WIDTH-1:0] mean_level;
    logic [ccrc_pkg::SIGMA_WIDTH-1:0]       sigma;
    ccrc_pkg::band_info_t                   info;
    ccrc_pkg::rule_flags_t                  flags;
    logic [POSITION_WIDTH-1:0]              position;

    ccrc_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .mean_level (mean_level),
        .sigma      (sigma)
    );

    ccrc_band_class #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_band (
        .sample     (in_sample_reg),
        .mean_level (mean_level),
        .sigma      (sigma),
        .info       (info)
    );

    ccrc_rule_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .sample       (in_sample_reg),
        .start_series (in_start_reg),
        .info         (info),
        .flags        (flags),
        .position     (position)
    );

    // Handshake: the held word moves on when the output register is free
    assign out_free      = !out_valid_reg || results.ready;
    assign advance       = in_valid_reg && out_free;
    assign samples.ready = !in_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= samples.sample;
            in_start_reg  <= samples.start_series;
        end
        if (advance)
        begin
            out_position_reg <= position;
            out_flags_reg    <= flags;
        end
    end

    // Result word
    assign results.valid                    = out_valid_reg;
    assign results.position                 = out_position_reg;
    assign results.beyond_three_sigma       = out_flags_reg.beyond_three_sigma;
    assign results.nine_same_side           = out_flags_reg.nine_same_side;
    assign results.six_trend                = out_flags_reg.six_trend;
    assign results.fourteen_alternating     = out_flags_reg.fourteen_alternating;
    assign results.two_of_three_beyond_two  = out_flags_reg.two_of_three_beyond_two;
    assign results.four_of_five_beyond_one  = out_flags_reg.four_of_five_beyond_one;
    assign results.fifteen_within_one       = out_flags_reg.fifteen_within_one;
    assign results.eight_outside_both_sides = out_flags_reg.eight_outside_both_sides;

    // A word that leaves the input stage is offered on the result side next cycle
    `CCRC_ASSERT(a_advance_fills_output, clk, rst_n, advance |=> results.valid)

endmodule
